[hdl/rse_pkg.sv]
package rse_pkg;

  localparam int DATA_W          = 32;
  localparam int OPND_W          = 31;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  typedef enum logic {
    TK_PUSH = 1'b0,
    TK_OP   = 1'b1
  } tok_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_MUL,
    BK_DIV,
    BK_FIN
  } bk_state_t;

  typedef struct packed {
    logic              req_type;
    logic [OPND_W-1:0] operand_value;
    logic [1:0]        operator_code;
    logic              last_item;
  } rse_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    status_t                  status;
  } rse_out_t;

  typedef struct packed {
    tok_kind_t         kind;
    logic [OPND_W-1:0] value;
    op_t               op;
    logic              last;
  } tok_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

[hdl/rse_front.sv]
module rse_front import rse_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  rse_in_t in_data,
  output logic    q_valid,
  output tok_t    q_tok,
  input  logic    q_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tok_t            q_mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  tok_t            tok_in;
  logic            push, pop;

  always_comb begin
    tok_in.kind  = in_data.req_type ? TK_OP : TK_PUSH;
    tok_in.value = in_data.operand_value;
    tok_in.op    = op_t'(in_data.operator_code);
    tok_in.last  = in_data.last_item;
  end

  assign in_stall = (count_r == CW'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_tok    = q_mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= tok_in;
    end
  end

endmodule

[hdl/rse_div.sv]
module rse_div import rse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NW = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.num[DATA_W-1] ? -req.num : req.num;
      den_nxt  = req.den[DATA_W-1] ? -req.den : req.den;
      neg_nxt  = req.num[DATA_W-1] ^ req.den[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + NW'(1);
      if (cnt_r == NW'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? -quo_r : quo_r;

endmodule

[hdl/rse_back.sv]
module rse_back import rse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  tok_t     q_tok,
  output logic     q_pop,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output logic     out_valid,
  input  logic     out_stall,
  output rse_out_t out_data
);

  localparam int IW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] mem_rd_r;
  logic              mem_we;
  logic [IW-1:0]     mem_wa, mem_ra;
  logic [SPW-1:0]    spm1, spm2;

  bk_state_t         state_r, state_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  status_t           err_r, err_nxt;
  logic [DATA_W-1:0] tos_r, tos_nxt;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  op_t               cur_op_r, cur_op_nxt;
  logic              cur_last_r, cur_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  rse_out_t          out_data_r, out_data_nxt;
  bk_state_t         after_op;
  logic              out_free;

  assign spm1     = sp_r - SPW'(1);
  assign spm2     = sp_r - SPW'(2);
  assign mem_wa   = spm1[IW-1:0];
  assign mem_ra   = spm2[IW-1:0];
  assign after_op = cur_last_r ? BK_FIN : BK_IDLE;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    prod_nxt      = prod_r;
    cur_op_nxt    = cur_op_r;
    cur_last_nxt  = cur_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    q_pop         = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = mem_rd_r;
    div_req.den   = tos_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          cur_op_nxt   = q_tok.op;
          cur_last_nxt = q_tok.last;
          state_nxt    = q_tok.last ? BK_FIN : BK_IDLE;
          if (err_r == ST_OK) begin
            if (q_tok.kind == TK_PUSH) begin
              if (sp_r >= SPW'(STACK_DEPTH)) begin
                err_nxt = ST_OVER;
              end else begin
                mem_we  = (sp_r != '0);
                tos_nxt = {1'b0, q_tok.value};
                sp_nxt  = sp_r + SPW'(1);
              end
            end else if (sp_r < SPW'(2)) begin
              err_nxt = ST_UNDER;
            end else begin
              state_nxt = BK_READ;
            end
          end
        end
      end
      BK_READ: begin
        case (cur_op_r)
          OP_ADD: begin
            tos_nxt   = mem_rd_r + tos_r;
            sp_nxt    = spm1;
            state_nxt = after_op;
          end
          OP_SUB: begin
            tos_nxt   = mem_rd_r - tos_r;
            sp_nxt    = spm1;
            state_nxt = after_op;
          end
          OP_MUL: begin
            prod_nxt  = mem_rd_r * tos_r;
            state_nxt = BK_MUL;
          end
          default: begin
            if (tos_r == '0) begin
              err_nxt   = ST_DIV0;
              state_nxt = after_op;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = BK_DIV;
            end
          end
        endcase
      end
      BK_MUL: begin
        tos_nxt   = prod_r;
        sp_nxt    = spm1;
        state_nxt = after_op;
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          tos_nxt   = div_rsp.quo;
          sp_nxt    = spm1;
          state_nxt = after_op;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r != ST_OK) begin
            out_data_nxt.status       = err_r;
            out_data_nxt.result_value = '0;
          end else if (sp_r == '0) begin
            out_data_nxt.status       = ST_UNDER;
            out_data_nxt.result_value = '0;
          end else begin
            out_data_nxt.status       = ST_OK;
            out_data_nxt.result_value = tos_r;
          end
          sp_nxt    = '0;
          err_nxt   = ST_OK;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      sp_r        <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r      <= tos_nxt;
    prod_r     <= prod_nxt;
    cur_op_r   <= cur_op_nxt;
    cur_last_r <= cur_last_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= tos_r;
    end
    mem_rd_r <= mem[mem_ra];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/rpn_stack_evaluator.sv]
// Postfix expression evaluator, one token per item.
// Input channel (in_valid/in_stall/in_data): a push token carries a 31-bit
// operand, an operator token applies add, subtract, multiply or divide to the
// top two stack entries. Tokens enter a two-item queue, so in_stall rises
// only when that queue is full.
// Result channel (out_valid/out_stall/out_data): one item per token marked
// last, holding the top of stack and a status code; the stack and any sticky
// error are then cleared. A result held by out_stall keeps its value, and
// tokens are still taken until the next last token waits for that register.
// In the execution unit a push is done in the idle state; add and subtract
// pass a read state, multiply a read and a multiply state, divide a read and
// a divide state (radix-2 divider, one quotient bit per cycle); a zero divisor
// ends in the read state, and a token after an error is only popped. Each
// accepted token is first registered in the queue; a last token then passes
// a finish state that loads the result register, which drives out_valid.
// Reset (rst_n low, synchronous) empties the queue and the stack, clears the
// error and drops any pending result. Stack RAM contents are not cleared.
module rpn_stack_evaluator import rse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rse_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rse_out_t out_data
);

  logic     q_valid;
  tok_t     q_tok;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  rse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .q_pop    (q_pop)
  );

  rse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_tok     (q_tok),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

[hdl/rse_checker.sv]
module rse_sva import rse_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input rse_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input rse_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.result_value == '0))
    else $error("error result carries a nonzero value");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present right after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind rpn_stack_evaluator rse_sva u_rse_sva (.*);

[tb/rse_checker.sv]
`timescale 1ns / 100ps

module rse_checker
  import rse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  rse_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  rse_out_t out_data,
  output int       mismatches,
  output int       pending
);

  logic [DATA_W-1:0] expr_stack [STACK_DEPTH_DEF];
  int                depth;
  status_t           sticky;
  rse_out_t          results_due [$];

  function automatic logic [DATA_W-1:0] trunc_quot(input logic [DATA_W-1:0] n,
                                                   input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] un;
    logic [DATA_W-1:0] ud;
    logic [DATA_W-1:0] q;
    un = n[DATA_W-1] ? 32'd0 - n : n;
    ud = d[DATA_W-1] ? 32'd0 - d : d;
    q  = un / ud;
    return (n[DATA_W-1] ^ d[DATA_W-1]) ? 32'd0 - q : q;
  endfunction

  task automatic take_token(input rse_in_t tok);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic              done;
    rse_out_t          res;
    if (sticky == ST_OK) begin
      if (tok.req_type == TK_PUSH) begin
        if (depth >= STACK_DEPTH_DEF) begin
          sticky = ST_OVER;
        end else begin
          expr_stack[depth] = {1'b0, tok.operand_value};
          depth++;
        end
      end else if (depth < 2) begin
        sticky = ST_UNDER;
      end else begin
        a    = expr_stack[depth-2];
        b    = expr_stack[depth-1];
        r    = '0;
        done = 1'b1;
        case (op_t'(tok.operator_code))
          OP_ADD: r = a + b;
          OP_SUB: r = a - b;
          OP_MUL: r = a * b;
          default: begin
            if (b == '0) begin
              sticky = ST_DIV0;
              done   = 1'b0;
            end else begin
              r = trunc_quot(a, b);
            end
          end
        endcase
        if (done) begin
          expr_stack[depth-2] = r;
          depth--;
        end
      end
    end
    if (tok.last_item) begin
      res.status       = sticky;
      res.result_value = '0;
      if (sticky == ST_OK) begin
        if (depth == 0) res.status = ST_UNDER;
        else res.result_value = expr_stack[depth-1];
      end
      results_due.push_back(res);
      depth  = 0;
      sticky = ST_OK;
    end
  endtask

  task automatic check_result(input rse_out_t got);
    rse_out_t want;
    if (results_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, got value %0d status %s",
               $time, got.result_value, got.status.name());
      mismatches++;
    end else begin
      want = results_due.pop_front();
      if (got.result_value !== want.result_value) begin
        $display("%0t: result_value expected %0d got %0d",
                 $time, want.result_value, got.result_value);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %s got %0d",
                 $time, want.status.name(), got.status);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      depth      = 0;
      sticky     = ST_OK;
      mismatches = 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) take_token(in_data);
    end
    pending <= results_due.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rse_pkg::*;

  localparam int ITEM_TARGET = 1500;
  localparam int IDLE_LIMIT  = 5000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rse_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rse_out_t out_data;
  int       mismatches;
  int       pending;
  int       items_sent;
  int       burst_left;
  int       idle_cycles;
  rse_in_t  expr [$];

  rpn_stack_evaluator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rse_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [OPND_W-1:0] rand_opnd();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 31'd1;
      2:       return 31'h7FFF_FFFF;
      3, 4, 5: return OPND_W'($urandom_range(0, 15));
      6:       return OPND_W'($urandom_range(0, 1000));
      default: return OPND_W'($urandom);
    endcase
  endfunction

  task automatic add_push(input logic [OPND_W-1:0] v);
    rse_in_t t;
    t.req_type      = TK_PUSH;
    t.operand_value = v;
    t.operator_code = 2'($urandom_range(0, 3));
    t.last_item     = 1'b0;
    expr.push_back(t);
  endtask

  task automatic add_op(input op_t o);
    rse_in_t t;
    t.req_type      = TK_OP;
    t.operand_value = OPND_W'($urandom);
    t.operator_code = o;
    t.last_item     = 1'b0;
    expr.push_back(t);
  endtask

  task automatic put_token(input rse_in_t t);
    int gap;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_expr();
    rse_in_t t;
    foreach (expr[i]) begin
      t = expr[i];
      if (i == expr.size() - 1) t.last_item = 1'b1;
      put_token(t);
    end
    expr.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // pick random stall patterns: none, one in four, one in two or eight in ten
  initial begin : rx
    int mode;
    int span;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int left;
    int lvl;
    int n;
    rse_in_t t;
    in_valid   <= 1'b0;
    in_data    <= '0;
    rst_n      <= 1'b0;
    items_sent  = 0;
    burst_left  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // wrap on multiply and add
    add_push(31'h7FFF_FFFF);
    add_push(31'h7FFF_FFFF);
    add_op(OP_MUL);
    add_push(31'h7FFF_FFFF);
    add_op(OP_ADD);
    send_expr();
    // negative quotient truncates toward zero
    add_push('0);
    add_push(31'd7);
    add_op(OP_SUB);
    add_push(31'd2);
    add_op(OP_DIV);
    send_expr();
    // most negative value divided by minus one
    add_push('0);
    add_push(31'h7FFF_FFFF);
    add_op(OP_SUB);
    add_push(31'd1);
    add_op(OP_SUB);
    add_push('0);
    add_push(31'd1);
    add_op(OP_SUB);
    add_op(OP_DIV);
    send_expr();
    // divide by zero, then ignored tokens
    add_push(31'd5);
    add_push('0);
    add_op(OP_DIV);
    add_push(31'd3);
    send_expr();
    // underflow
    add_push(31'd1);
    add_op(OP_ADD);
    send_expr();
    // two entries left, top returned
    add_push(31'd1);
    add_push(31'd2);
    send_expr();
    drain();

    while (items_sent < ITEM_TARGET) begin
      n = $urandom_range(0, 99);
      if (n < 80) begin
        left = (n < 70) ? $urandom_range(1, 8) : $urandom_range(9, 30);
        lvl  = 0;
        while (left > 0 || lvl > 1) begin
          if (lvl < 2 || (left > 0 && $urandom_range(0, 1) == 1)) begin
            add_push(rand_opnd());
            left--;
            lvl++;
          end else begin
            add_op(op_t'($urandom_range(0, 3)));
            lvl--;
          end
        end
        if ($urandom_range(0, 7) == 0) add_push(rand_opnd());
      end else if (n < 85) begin
        // push up to near or past the stack depth
        repeat ($urandom_range(60, 68)) add_push(rand_opnd());
        repeat ($urandom_range(0, 4)) add_op(op_t'($urandom_range(0, 3)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          t.req_type      = 1'($urandom_range(0, 1));
          t.operand_value = rand_opnd();
          t.operator_code = 2'($urandom_range(0, 3));
          t.last_item     = ($urandom_range(0, 3) == 0);
          expr.push_back(t);
        end
      end
      send_expr();
      if ($urandom_range(0, 99) == 0) drain();
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
